### hdl/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg: shared types and constants of the positional list store
// Opcodes, status codes, field widths and the sequencer states.
// ----------------------------------------------------------------------------
package pls_pkg;

  localparam int unsigned DEF_CAPACITY = 64;
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned POS_W        = 7;
  localparam int unsigned CNT_W        = 7;
  localparam int unsigned OP_W         = 3;
  localparam int unsigned STAT_W       = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_INSERT_AT  = 3'd4,
    OP_ERASE_AT   = 3'd5,
    OP_CLEAR      = 3'd6,
    OP_NOP        = 3'd7
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_FULL  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_ERA_RD,
    S_ERA_CAP,
    S_ERA_MV,
    S_EMIT
  } state_e;

endpackage

### hdl/pls_in_if.sv
// ----------------------------------------------------------------------------
// pls_in_if: request channel of the positional list store
// Valid/ready handshake carrying opcode, value and position.
// ----------------------------------------------------------------------------
interface pls_in_if import pls_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    opcode;
  logic signed [VAL_W-1:0] value;
  logic [POS_W-1:0]   position;

  modport source (output valid, output opcode, output value, output position, input ready);
  modport sink   (input valid, input opcode, input value, input position, output ready);
endinterface

### hdl/pls_out_if.sv
// ----------------------------------------------------------------------------
// pls_out_if: response channel of the positional list store
// Valid/ready handshake carrying removed value, status and item count.
// ----------------------------------------------------------------------------
interface pls_out_if import pls_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [VAL_W-1:0] removed_value;
  logic [STAT_W-1:0]  status;
  logic [CNT_W-1:0]   item_count;

  modport source (output valid, output removed_value, output status, output item_count,
                  input ready);
  modport sink   (input valid, input removed_value, input status, input item_count,
                  output ready);
endinterface

### hdl/pls_ram.sv
// ----------------------------------------------------------------------------
// pls_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pls_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/positional_list_store.sv
// Failed operations, clear and no-op go from acceptance straight to the emit step.
// Push and insert first move the entries from the position on up by one place, then
// write the new value; pop and erase read the entry and move the ones behind it down.
// One item at a time: the next request is taken once the last reply is in the output
// register; the single RAM write port moves one entry per cycle while entries shift.
// Reset: the fill count and all handshake state clear at once; the entry RAM is not cleared.
// ----------------------------------------------------------------------------
// positional_list_store: bounded ordered list with positional insert and erase
// Values are kept packed in list order in one RAM; insert and erase shift the
// entries behind the position by one place, one entry per cycle.
// ----------------------------------------------------------------------------
module positional_list_store import pls_pkg::*; #(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  pls_in_if.sink  req_i,
  pls_out_if.source rsp_o
);

  // Address width of the entry RAM and width of a count that can hold CAPACITY.
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  // Common width for comparing the request position against the count.
  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

  state_e state_q, state_d;

  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    pos_q, pos_d;
  logic [VAL_W-1:0] val_q, val_d;
  logic             wr_pend_q, wr_pend_d;
  logic [AW-1:0]    wr_addr_q, wr_addr_d;
  logic [VAL_W-1:0] res_rem_q, res_rem_d;
  status_e          res_st_q, res_st_d;

  logic             out_valid_q, out_valid_d;
  logic [VAL_W-1:0] out_rem_q, out_rem_d;
  status_e          out_st_q, out_st_d;
  logic [CNT_W-1:0] out_cnt_q, out_cnt_d;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [VAL_W-1:0] ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [VAL_W-1:0] ram_rdata;

  logic [CW-1:0]    idx_dec, idx_inc;
  logic [PW-1:0]    pos_ext, cnt_ext;
  logic             is_full, is_empty;

  pls_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign idx_dec  = idx_q - 1'b1;
  assign idx_inc  = idx_q + 1'b1;
  assign pos_ext  = PW'(req_i.position);
  assign cnt_ext  = PW'(count_q);
  assign is_full  = (cnt_ext >= PW'(CAPACITY));
  assign is_empty = (count_q == '0);

  // New requests are taken only while the sequencer is idle. A finished beat may
  // still sit in the output register; it is only needed free when the next
  // result is ready to be handed over.
  assign req_i.ready = (state_q == S_IDLE);

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.removed_value = out_rem_q;
  assign rsp_o.status        = out_st_q;
  assign rsp_o.item_count    = out_cnt_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    val_d       = val_q;
    wr_pend_d   = wr_pend_q;
    wr_addr_d   = wr_addr_q;
    res_rem_d   = res_rem_q;
    res_st_d    = res_st_q;
    out_rem_d   = out_rem_q;
    out_st_d    = out_st_q;
    out_cnt_d   = out_cnt_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    ram_we      = 1'b0;
    ram_waddr   = wr_addr_q;
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = pos_q[AW-1:0];

    unique case (state_q) inside
      S_IDLE: begin
        if (req_i.valid) begin
          // Default outcome: nothing removed, status ok, straight to the output.
          res_rem_d = '0;
          res_st_d  = STAT_OK;
          state_d   = S_EMIT;
          val_d     = req_i.value;
          wr_pend_d = 1'b0;
          idx_d     = count_q;
          unique case (op_e'(req_i.opcode)) inside
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              if (is_full) begin
                res_st_d = STAT_FULL;
              end else begin
                pos_d   = (op_e'(req_i.opcode) == OP_PUSH_FRONT) ? '0 : count_q;
                state_d = S_INS;
              end
            end
            OP_INSERT_AT: begin
              // The range check wins over the full check.
              if (pos_ext > cnt_ext) begin
                res_st_d = STAT_RANGE;
              end else if (is_full) begin
                res_st_d = STAT_FULL;
              end else begin
                pos_d   = pos_ext[CW-1:0];
                state_d = S_INS;
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (is_empty) begin
                res_st_d = STAT_EMPTY;
              end else begin
                pos_d   = (op_e'(req_i.opcode) == OP_POP_FRONT) ? '0 : count_q - 1'b1;
                state_d = S_ERA_RD;
              end
            end
            OP_ERASE_AT: begin
              if (is_empty) begin
                res_st_d = STAT_EMPTY;
              end else if (pos_ext >= cnt_ext) begin
                res_st_d = STAT_RANGE;
              end else begin
                pos_d   = pos_ext[CW-1:0];
                state_d = S_ERA_RD;
              end
            end
            OP_CLEAR: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_INS: begin
        // Walk down from the tail: read entry idx-1, write it to idx in the cycle
        // after. Reads always run below the pending write, so no hazard.
        ram_we = wr_pend_q;
        if (idx_q > pos_q) begin
          ram_re    = 1'b1;
          ram_raddr = idx_dec[AW-1:0];
          wr_pend_d = 1'b1;
          wr_addr_d = idx_q[AW-1:0];
          idx_d     = idx_dec;
        end else if (wr_pend_q) begin
          wr_pend_d = 1'b0;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = pos_q[AW-1:0];
          ram_wdata = val_q;
          count_d   = count_q + 1'b1;
          state_d   = S_EMIT;
        end
      end

      S_ERA_RD: begin
        ram_re    = 1'b1;
        ram_raddr = pos_q[AW-1:0];
        idx_d     = pos_q + 1'b1;
        wr_pend_d = 1'b0;
        state_d   = S_ERA_CAP;
      end

      S_ERA_CAP, S_ERA_MV: begin
        // Walk up from the erased slot: read entry idx, write it to idx-1 in the
        // cycle after. The first cycle also captures the removed value.
        if (state_q == S_ERA_CAP) begin
          res_rem_d = ram_rdata;
        end
        ram_we  = wr_pend_q;
        state_d = S_ERA_MV;
        if (idx_q < count_q) begin
          ram_re    = 1'b1;
          ram_raddr = idx_q[AW-1:0];
          wr_pend_d = 1'b1;
          wr_addr_d = idx_dec[AW-1:0];
          idx_d     = idx_inc;
        end else if (wr_pend_q) begin
          wr_pend_d = 1'b0;
        end else begin
          count_d = count_q - 1'b1;
          state_d = S_EMIT;
        end
      end

      S_EMIT: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_rem_d   = res_rem_q;
          out_st_d    = res_st_q;
          out_cnt_d   = cnt_ext[CNT_W-1:0];
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      wr_pend_q   <= wr_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and walk registers.
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    pos_q     <= pos_d;
    val_q     <= val_d;
    wr_addr_q <= wr_addr_d;
    res_rem_q <= res_rem_d;
    res_st_q  <= res_st_d;
    out_rem_q <= out_rem_d;
    out_st_q  <= out_st_d;
    out_cnt_q <= out_cnt_d;
  end

`ifndef SYNTH
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_ext <= PW'(CAPACITY))
    else $error("fill count exceeds capacity");

  a_no_same_addr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re && (ram_waddr == ram_raddr)))
    else $error("read and write of the same entry in one cycle");

  a_accept_leaves_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> (state_q != S_IDLE))
    else $error("accepted beat did not start the sequencer");

  a_result_from_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_EMIT))
    else $error("result beat appeared outside the emit step");
`endif

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the positional list store
// Requests go in through a valid/ready driver and replies come out through a
// monitor. Every accepted request is run through an in-bench list predictor,
// and each reply beat is compared field by field against the oldest
// prediction. The run has four pacing mixes: no gaps, sender gaps, receiver
// stalls, and both. Between mixes the sender holds off until every reply is in.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pls_pkg::*;

  localparam int unsigned CAPACITY   = DEF_CAPACITY;
  // The bench keeps two copies of the list. The check copy advances only on
  // accepted request beats and produces the expected replies. The plan copy
  // advances as the stimulus is generated, so the generator knows how full
  // the list will be and can aim positions and operations at real content.
  localparam int unsigned CHECK_COPY = 0;
  localparam int unsigned PLAN_COPY  = 1;
  // The timeout leaves a wide margin over the slowest legal run (about 770
  // requests, plus random gaps and stalls).
  localparam int unsigned TIMEOUT_NS = 6_000_000;
  // Mismatch lines stop printing after this many, but counting goes on.
  localparam int unsigned PRINT_CAP  = 40;

  typedef struct packed {
    op_e                     opcode;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } list_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] removed_value;
    status_e                 status;
    logic [CNT_W-1:0]        item_count;
  } list_reply_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // The driver and monitor registers start at known values and feed the
  // interfaces through continuous assignments. That way every block input
  // is defined from time zero, before the first clock edge.
  logic                    drv_valid    = 1'b0;
  logic [OP_W-1:0]         drv_opcode   = OP_NOP;
  logic signed [VAL_W-1:0] drv_value    = '0;
  logic [POS_W-1:0]        drv_position = '0;
  logic                    rsp_ready    = 1'b0;

  pls_in_if  req_if ();
  pls_out_if rsp_if ();

  assign req_if.valid    = drv_valid;
  assign req_if.opcode   = drv_opcode;
  assign req_if.value    = drv_value;
  assign req_if.position = drv_position;
  assign rsp_if.ready    = rsp_ready;

  positional_list_store #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // List contents, one row per copy. Only entries below the length are ever
  // read, and they were all written first.
  logic signed [VAL_W-1:0] list_vals [2][CAPACITY];
  int unsigned             list_len  [2];

  list_req_t   request_backlog [$];
  list_reply_t expected_replies [$];

  int unsigned gap_pct        = 0;
  int unsigned stall_pct      = 0;
  int unsigned gen_target     = 0;
  int unsigned mismatch_count = 0;
  int unsigned requests_taken = 0;
  int unsigned replies_seen   = 0;
  int unsigned longest_list   = 0;
  int unsigned status_seen [4];

  // Applies one request to the chosen copy of the list and returns the reply
  // that the block must give for it. Range is checked before fullness on
  // insert, and emptiness is checked before range on erase.
  function automatic list_reply_t apply_list_op(int unsigned k, list_req_t r);
    list_reply_t res;
    int unsigned n;
    int unsigned at;
    int unsigned i;
    n = list_len[k];
    at = 0;
    res.removed_value = '0;
    res.status = STAT_OK;
    case (r.opcode) inside
      OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_AT: begin
        if (r.opcode == OP_PUSH_FRONT) at = 0;
        else if (r.opcode == OP_PUSH_BACK) at = n;
        else at = r.position;
        if (at > n) begin
          res.status = STAT_RANGE;
        end else if (n >= CAPACITY) begin
          res.status = STAT_FULL;
        end else begin
          for (i = n; i > at; i--) list_vals[k][i] = list_vals[k][i-1];
          list_vals[k][at] = r.value;
          list_len[k] = n + 1;
        end
      end
      OP_POP_FRONT, OP_POP_BACK, OP_ERASE_AT: begin
        if (n == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          if (r.opcode == OP_POP_FRONT) at = 0;
          else if (r.opcode == OP_POP_BACK) at = n - 1;
          else at = r.position;
          if (at >= n) begin
            res.status = STAT_RANGE;
          end else begin
            res.removed_value = list_vals[k][at];
            for (i = at; i + 1 < n; i++) list_vals[k][i] = list_vals[k][i+1];
            list_len[k] = n - 1;
          end
        end
      end
      OP_CLEAR: list_len[k] = 0;
      default: ;
    endcase
    res.item_count = CNT_W'(list_len[k]);
    return res;
  endfunction

  task automatic flag_mismatch(string what);
    if (mismatch_count < PRINT_CAP) $display("MISMATCH at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  // Values lean toward the extremes now and then, otherwise fully random.
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(15))
      0:       return {1'b1, {(VAL_W-1){1'b0}}};
      1:       return {1'b0, {(VAL_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  task automatic queue_req(op_e op, logic signed [VAL_W-1:0] v, logic [POS_W-1:0] p);
    list_req_t r;
    r.opcode = op;
    r.value = v;
    r.position = p;
    request_backlog.insert(request_backlog.size(), r);
    void'(apply_list_op(PLAN_COPY, r));
  endtask

  // Random requests are mostly well-formed. Each one steers the list toward
  // a target length that is often empty or full, so the list walks the whole
  // range and sits at both ends. When the target is reached, a noise request
  // (any opcode, any position) goes in, which gives failed pushes on a full
  // list and failed pops on an empty one. Then a new target is picked.
  task automatic queue_random(int unsigned n);
    int unsigned len;
    int unsigned roll;
    logic [POS_W-1:0] noise_pos;
    repeat (n) begin
      len = list_len[PLAN_COPY];
      roll = $urandom_range(99);
      if ($urandom_range(1) != 0) noise_pos = POS_W'($urandom_range(127));
      else noise_pos = POS_W'($urandom_range(len + 1));
      if (roll == 0) begin
        queue_req(OP_CLEAR, pick_value(), noise_pos);
      end else if (roll < 12 || len == gen_target) begin
        queue_req(op_e'($urandom_range(7)), pick_value(), noise_pos);
        if (len == gen_target) begin
          case ($urandom_range(9))
            0, 1, 2: gen_target = 0;
            3, 4, 5: gen_target = CAPACITY;
            default: gen_target = $urandom_range(CAPACITY);
          endcase
        end
      end else if (len < gen_target) begin
        case ($urandom_range(2))
          0:       queue_req(OP_PUSH_FRONT, pick_value(), noise_pos);
          1:       queue_req(OP_PUSH_BACK, pick_value(), noise_pos);
          default: queue_req(OP_INSERT_AT, pick_value(), POS_W'($urandom_range(len)));
        endcase
      end else begin
        case ($urandom_range(2))
          0:       queue_req(OP_POP_FRONT, pick_value(), noise_pos);
          1:       queue_req(OP_POP_BACK, pick_value(), noise_pos);
          default: queue_req(OP_ERASE_AT, pick_value(), POS_W'($urandom_range(len - 1)));
        endcase
      end
    end
  endtask

  // The sender holds off here until every queued request is taken and every
  // reply has come back, so the block is idle at each mix boundary.
  task automatic drain_all();
    while (request_backlog.size() != 0 || expected_replies.size() != 0 || drv_valid)
      @(posedge clk_i);
  endtask

  // Request driver. On the edge where a beat is taken, the request that was
  // on the bus goes through the check copy and its reply is queued. A new
  // beat is offered only when the bus is free or was just taken, and the
  // random gap decides whether the sender idles for this cycle. Each
  // register gets one nonblocking assignment per edge, so a valid that stays
  // high for back-to-back beats is never lowered and raised in the same step.
  always @(posedge clk_i or negedge rst_ni) begin : request_driver
    list_req_t taken;
    list_req_t next_req;
    if (!rst_ni) begin
      drv_valid    <= 1'b0;
      drv_opcode   <= OP_NOP;
      drv_value    <= '0;
      drv_position <= '0;
    end else begin
      if (drv_valid && req_if.ready) begin
        taken.opcode   = op_e'(drv_opcode);
        taken.value    = drv_value;
        taken.position = drv_position;
        expected_replies.insert(expected_replies.size(), apply_list_op(CHECK_COPY, taken));
        requests_taken++;
        if (list_len[CHECK_COPY] > longest_list) longest_list = list_len[CHECK_COPY];
      end
      if (!drv_valid || req_if.ready) begin
        if (request_backlog.size() != 0 && $urandom_range(99) >= gap_pct) begin
          next_req = request_backlog.pop_front();
          drv_valid    <= 1'b1;
          drv_opcode   <= next_req.opcode;
          drv_value    <= next_req.value;
          drv_position <= next_req.position;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // Reply monitor. A reply beat is taken when valid and ready are both high
  // at the edge. It is compared with the oldest expected reply, and a beat
  // with nothing expected is an error. Ready is redrawn on every cycle from
  // the stall percentage.
  always @(posedge clk_i or negedge rst_ni) begin : reply_monitor
    list_reply_t want;
    if (!rst_ni) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_ready) begin
        if (expected_replies.size() == 0) begin
          flag_mismatch($sformatf("unexpected reply: removed %0d status %0d count %0d",
                                  rsp_if.removed_value, rsp_if.status, rsp_if.item_count));
        end else begin
          want = expected_replies.pop_front();
          replies_seen++;
          status_seen[want.status]++;
          if (rsp_if.removed_value !== want.removed_value)
            flag_mismatch($sformatf("reply %0d: removed value %0d, expected %0d",
                                    replies_seen, rsp_if.removed_value, want.removed_value));
          if (rsp_if.status !== want.status)
            flag_mismatch($sformatf("reply %0d: status %0d, expected %0d",
                                    replies_seen, rsp_if.status, want.status));
          if (rsp_if.item_count !== want.item_count)
            flag_mismatch($sformatf("reply %0d: item count %0d, expected %0d",
                                    replies_seen, rsp_if.item_count, want.item_count));
        end
      end
      rsp_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed opening, with no gaps and no stalls. It covers every
    // failure on an empty list, inserts at the front, the end and the
    // middle with extreme values, range errors on insert and erase
    // (including a position equal to the count), pops from both ends, the
    // no-op code, and clear followed by a pop.
    gap_pct = 0;
    stall_pct = 0;
    queue_req(OP_POP_FRONT, '0, '0);
    queue_req(OP_POP_BACK, '0, '0);
    queue_req(OP_ERASE_AT, '0, '0);
    queue_req(OP_ERASE_AT, '1, 7'd127);
    queue_req(OP_INSERT_AT, 32'sd5, 7'd1);
    queue_req(OP_INSERT_AT, {1'b1, 31'd0}, 7'd0);
    queue_req(OP_PUSH_FRONT, {1'b0, {31{1'b1}}}, 7'd127);
    queue_req(OP_PUSH_BACK, '1, 7'd64);
    queue_req(OP_PUSH_BACK, '0, '0);
    queue_req(OP_INSERT_AT, 32'h5555_5555, 7'd4);
    queue_req(OP_INSERT_AT, 32'hAAAA_AAAA, 7'd2);
    queue_req(OP_INSERT_AT, 32'sd9, 7'd127);
    queue_req(OP_ERASE_AT, '0, 7'd6);
    queue_req(OP_ERASE_AT, '0, 7'd127);
    queue_req(OP_ERASE_AT, '0, 7'd3);
    queue_req(OP_ERASE_AT, '0, 7'd0);
    queue_req(OP_POP_FRONT, '1, 7'd64);
    queue_req(OP_POP_BACK, '0, '0);
    queue_req(OP_NOP, pick_value(), POS_W'($urandom_range(127)));
    queue_req(OP_PUSH_BACK, 32'sd123, '0);
    queue_req(OP_CLEAR, '1, '1);
    queue_req(OP_POP_BACK, '0, '0);
    queue_req(OP_PUSH_FRONT, 32'sd7, '0);
    queue_req(OP_ERASE_AT, '0, '0);
    gen_target = CAPACITY;
    queue_random(190);
    drain_all();

    // Sender gaps only.
    @(negedge clk_i);
    gap_pct = 51;
    stall_pct = 0;
    queue_random(190);
    drain_all();

    // Receiver stalls only.
    @(negedge clk_i);
    gap_pct = 0;
    stall_pct = 51;
    queue_random(190);
    drain_all();

    // Gaps and stalls together.
    @(negedge clk_i);
    gap_pct = 37;
    stall_pct = 37;
    queue_random(180);
    drain_all();

    // Give a stray late reply time to show up before the verdict.
    repeat (CAPACITY + 8) @(posedge clk_i);

    $display("Covered %0d requests under four pacing mixes; longest list %0d of %0d.",
             requests_taken, longest_list, CAPACITY);
    $display("Replies checked: %0d (ok %0d, empty %0d, range %0d, full %0d), mismatches %0d.",
             replies_seen, status_seen[STAT_OK], status_seen[STAT_EMPTY],
             status_seen[STAT_RANGE], status_seen[STAT_FULL], mismatch_count);
    if (mismatch_count == 0 && expected_replies.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Timed out with %0d requests queued and %0d replies outstanding.",
             request_backlog.size(), expected_replies.size());
    $display("testbench NOT OK");
    $finish;
  end

endmodule
